// File: hw/rtl/sfd_pkg.sv
// shared types, constants and arithmetic helpers for the stereo feedback delay
`timescale 1ns / 1ps

package sfd_pkg;

	localparam int ADDR_W      = 15;
	localparam int DEPTH       = 1 << ADDR_W;
	localparam int SAMPLE_BITS = 16;
	localparam int GAIN_FRAC   = 14;
	localparam int DELAY_W     = 15;
	localparam int FB_W        = 16;
	localparam int GAIN_W      = 18;
	localparam int CFG_W       = 18;
	localparam int CFG_IDX_W   = 2;
	localparam int PROD_W      = GAIN_W + 1 + SAMPLE_BITS;
	localparam int FBP_W       = FB_W + SAMPLE_BITS;
	localparam int SUM_W       = PROD_W + 2;

	localparam logic [DELAY_W-1:0]       DELAY_RESET = DELAY_W'(2205);
	localparam logic signed [FB_W-1:0]   FB_RESET    = FB_W'(6144);
	localparam logic [GAIN_W-1:0]        WET_RESET   = GAIN_W'(16384);
	localparam logic [GAIN_W-1:0]        DRY_RESET   = GAIN_W'(16384);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY = 2'd0,
		REG_FB    = 2'd1,
		REG_WET   = 2'd2,
		REG_DRY   = 2'd3
	} cfg_reg_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t right;
		sample_t left;
	} frame_t;

	// round a Q.14 sum (ties toward plus infinity) and saturate to a sample
	function automatic sample_t round_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] t;
		logic signed [SUM_W-1:0] sh;
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
		lo = -hi - SUM_W'(1);
		t  = v + SUM_W'(1 << (GAIN_FRAC - 1));
		sh = t >>> GAIN_FRAC;
		if (sh > hi)
			return hi[SAMPLE_BITS-1:0];
		else if (sh < lo)
			return lo[SAMPLE_BITS-1:0];
		else
			return sh[SAMPLE_BITS-1:0];
	endfunction

endpackage

// File: hw/rtl/sfd_if.sv
// stream interfaces for input frames and mixed output frames
`timescale 1ns / 1ps

interface sfd_in_if
	import sfd_pkg::*;
;
	logic    valid;
	logic    ready;
	sample_t left_sample;
	sample_t right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sfd_out_if
	import sfd_pkg::*;
;
	logic    valid;
	logic    ready;
	sample_t left_out;
	sample_t right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// File: hw/rtl/sfd_store.sv
// delay line memory with registered read and a clearing sweep after reset
`timescale 1ns / 1ps

module sfd_store
	import sfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output frame_t            rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  frame_t            wr_data,
	output logic              clr_busy
);

	frame_t            mem [DEPTH];
	frame_t            rd_data_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_busy_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	frame_t            wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == {ADDR_W{1'b1}})
				clr_busy_q <= 1'b0;
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = wr_en;
			waddr = wr_addr;
			wdata = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read-first: a write to the same frame in this cycle is not seen
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

endmodule

// File: hw/rtl/sfd_lane.sv
// one channel of the mix: registered products, then sum, round and saturate
`timescale 1ns / 1ps

module sfd_lane
	import sfd_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  sample_t                 x,
	input  sample_t                 d,
	input  logic signed [FB_W-1:0]  fb_gain,
	input  logic [GAIN_W-1:0]       wet_gain,
	input  logic [GAIN_W-1:0]       dry_gain,
	output sample_t                 mix_out,
	output sample_t                 rec_out
);

	logic signed [PROD_W-1:0] prod_dry_s2;
	logic signed [PROD_W-1:0] prod_wet_s2;
	logic signed [FBP_W-1:0]  prod_fb_s2;
	sample_t                  x_s2;

	logic signed [GAIN_W:0]   dry_sg;
	logic signed [GAIN_W:0]   wet_sg;
	logic signed [SUM_W-1:0]  mix_sum;
	logic signed [SUM_W-1:0]  rec_sum;

	assign dry_sg = $signed({1'b0, dry_gain});
	assign wet_sg = $signed({1'b0, wet_gain});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_dry_s2 <= dry_sg * x;
			prod_wet_s2 <= wet_sg * d;
			prod_fb_s2  <= fb_gain * d;
			x_s2        <= x;
		end
	end

	assign mix_sum = SUM_W'(prod_dry_s2) + SUM_W'(prod_wet_s2);
	assign rec_sum = (SUM_W'(x_s2) <<< GAIN_FRAC) + SUM_W'(prod_fb_s2);

	assign mix_out = round_sat(mix_sum);
	assign rec_out = round_sat(rec_sum);

endmodule

// File: hw/rtl/stereo_feedback_delay_top.sv
// path: an accepted request passes the s1, s2 and output registers before its result is offered
// rate: one frame per cycle while the output is taken; a delay of one or two
//   frames waits for the pending store write
// reset: configuration, pointer and valid registers to their defaults, then a
//   clearing sweep over all 32768 frames of the delay memory during which no request is taken
`timescale 1ns / 1ps

module stereo_feedback_delay_top
	import sfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	sfd_in_if.sink               in_ch,
	sfd_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic signed [FB_W-1:0]  fb_q;
	logic [GAIN_W-1:0]       wet_q;
	logic [GAIN_W-1:0]       dry_q;
	logic [ADDR_W-1:0]       rp_q;
	logic [ADDR_W-1:0]       wp_q;

	logic                    valid_s1;
	logic                    valid_s2;
	logic [ADDR_W-1:0]       wp_s1;
	logic [ADDR_W-1:0]       wp_s2;
	frame_t                  x_s1;
	logic                    out_valid_q;
	frame_t                  out_q;

	frame_t                  rd_data;
	frame_t                  mix;
	frame_t                  rec;
	logic                    clr_busy;
	logic                    adv;
	logic                    hazard;
	logic                    in_fire;

	// whole pipeline holds while the output register is full and not taken
	assign adv = !out_valid_q || out_ch.ready;

	// frame about to be read still has a write in flight
	assign hazard = (valid_s1 && (wp_s1 == rp_q)) || (valid_s2 && (wp_s2 == rp_q));

	assign in_ch.ready = !clr_busy && adv && !hazard;
	assign in_fire     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q    <= FB_RESET;
			wet_q   <= WET_RESET;
			dry_q   <= DRY_RESET;
			rp_q    <= '0;
			wp_q    <= ADDR_W'(DELAY_RESET);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DELAY: begin
					wp_q    <= rp_q + ADDR_W'(cfg_data[DELAY_W-1:0]);
				end
				REG_FB:  fb_q  <= $signed(cfg_data[FB_W-1:0]);
				REG_WET: wet_q <= cfg_data[GAIN_W-1:0];
				REG_DRY: dry_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end else if (in_fire) begin
			rp_q <= rp_q + ADDR_W'(1);
			wp_q <= wp_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_fire;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_s1.left  <= in_ch.left_sample;
			x_s1.right <= in_ch.right_sample;
			wp_s1      <= wp_q;
		end
		if (adv) begin
			wp_s2 <= wp_s1;
			out_q <= mix;
		end
	end

	sfd_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_fire),
		.rd_addr  (rp_q),
		.rd_data  (rd_data),
		.wr_en    (valid_s2 && adv),
		.wr_addr  (wp_s2),
		.wr_data  (rec),
		.clr_busy (clr_busy)
	);

	sfd_lane u_lane_left (
		.clk      (clk),
		.en       (adv),
		.x        (x_s1.left),
		.d        (rd_data.left),
		.fb_gain  (fb_q),
		.wet_gain (wet_q),
		.dry_gain (dry_q),
		.mix_out  (mix.left),
		.rec_out  (rec.left)
	);

	sfd_lane u_lane_right (
		.clk      (clk),
		.en       (adv),
		.x        (x_s1.right),
		.d        (rd_data.right),
		.fb_gain  (fb_q),
		.wet_gain (wet_q),
		.dry_gain (dry_q),
		.mix_out  (mix.right),
		.rec_out  (rec.right)
	);

	assign out_ch.valid     = out_valid_q;
	assign out_ch.left_out  = out_q.left;
	assign out_ch.right_out = out_q.right;

endmodule
